>>> src/sts_pkg.sv
`timescale 1ns / 1ps
package sts_pkg;

    localparam int KW_COUNT = 45;

    typedef enum logic [6:0] {
        T_LPAREN   = 7'd45,
        T_RPAREN   = 7'd46,
        T_COMMA    = 7'd47,
        T_SEMI     = 7'd48,
        T_STAR     = 7'd49,
        T_DOT      = 7'd50,
        T_EQ       = 7'd51,
        T_NE       = 7'd52,
        T_LT       = 7'd53,
        T_LE       = 7'd54,
        T_GT       = 7'd55,
        T_GE       = 7'd56,
        T_PLUS     = 7'd57,
        T_MINUS    = 7'd58,
        T_SLASH    = 7'd59,
        T_INTLIT   = 7'd60,
        T_FLOATLIT = 7'd61,
        T_STRLIT   = 7'd62,
        T_IDENT    = 7'd63,
        T_EOF      = 7'd64,
        T_INVALID  = 7'd65
    } tok_t;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUM, M_NUMDOT, M_STR, M_STRQ, M_STRESC, M_LT, M_GT,
        M_BANG, M_MINUS, M_SLASH, M_LINECMT, M_BLOCK, M_BLOCKSTAR
    } mode_t;

    typedef struct packed {
        logic        kind;
        logic [6:0]  ttype;
        logic [7:0]  value;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } res_t;

    // up to three results per byte; the word's tail is finished in the back part
    typedef struct packed {
        logic [1:0]  count;
        res_t [2:0]  res;
        logic        kw_check;   // res[0] is a word completion awaiting lookup
        logic [63:0] kw_text;
        logic [3:0]  kw_len;
    } bundle_t;

    function automatic logic [63:0] kw_word(input int i);
        logic [63:0] w;
        w = '0;
        case (i)
            0: w = "CREATE"; 1: w = "DROP"; 2: w = "TABLE"; 3: w = "INDEX";
            4: w = "PRIMARY"; 5: w = "KEY"; 6: w = "SELECT"; 7: w = "INSERT";
            8: w = "UPDATE"; 9: w = "DELETE"; 10: w = "FROM"; 11: w = "WHERE";
            12: w = "INTO"; 13: w = "VALUES"; 14: w = "SET"; 15: w = "AND";
            16: w = "OR"; 17: w = "NOT"; 18: w = "IS"; 19: w = "NULL";
            20: w = "TRUE"; 21: w = "FALSE"; 22: w = "JOIN"; 23: w = "INNER";
            24: w = "LEFT"; 25: w = "RIGHT"; 26: w = "OUTER"; 27: w = "CROSS";
            28: w = "ON"; 29: w = "AS"; 30: w = "ORDER"; 31: w = "BY";
            32: w = "ASC"; 33: w = "DESC"; 34: w = "LIMIT"; 35: w = "OFFSET";
            36: w = "INT"; 37: w = "INTEGER"; 38: w = "BIGINT"; 39: w = "SMALLINT";
            40: w = "BOOLEAN"; 41: w = "VARCHAR"; 42: w = "TEXT"; 43: w = "FLOAT";
            44: w = "DOUBLE";
            default: w = '0;
        endcase
        return w;
    endfunction

    // keyword text is left aligned: first byte in [63:56], zero padded
    function automatic logic [63:0] kw_padded(input int i);
        logic [63:0] w;
        logic [63:0] r;
        int          n;
        w = kw_word(i);
        n = 0;
        for (int k = 0; k < 8; k++)
            if (w[k*8 +: 8] != 8'd0) n = k + 1;
        r = w << (8 * (8 - n));
        return r;
    endfunction

endpackage

>>> src/sql_token_scanner.sv
`timescale 1ns / 1ps
// SQL token scanner.
// Input channel (in_valid/in_ready): one word per byte of text, or an end of
// text marker (operation = 1) that flushes the pending token and emits an end token.
// Output channel (out_valid/out_ready): one result per word, either a value
// byte of the current token or a token completion, with end line and start
// column. last_of_run marks the final result caused by one input word.
// A byte is classified by the front scanner and placed in a two-entry
// queue; the back end issues its results one per cycle while out_ready is
// high, through a registered output, finishing the keyword lookup on the way.
// Throughput: one byte per cycle while out_ready is high and each byte gives
// at most one result; a byte giving two or three results holds the back end
// until all are issued. Each bundle passes the queue and the output register.
// Reset empties the queue, clears the output valid flag and returns the scanner to
// line 1, column 1, between tokens.
// A stalled receiver fills the queue, after which in_ready drops.
module sql_token_scanner #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [6:0]  token_type,
    output logic [7:0]  value_byte,
    output logic [15:0] token_line,
    output logic [15:0] token_column,
    output logic        last_of_run
);

    logic             push, full, empty, pop;
    sts_pkg::bundle_t bundle, head;
    sts_pkg::res_t    res;

    sts_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .operation, .text_byte,
        .push, .bundle, .full
    );

    sts_queue u_queue (
        .clk, .rst_n, .push, .push_data(bundle), .full, .empty, .pop, .head
    );

    sts_back u_back (
        .clk, .rst_n, .empty, .head, .pop, .out_valid, .out_ready, .out_res(res)
    );

    assign result_kind  = res.kind;
    assign token_type   = res.ttype;
    assign value_byte   = res.value;
    assign token_line   = res.line;
    assign token_column = res.column;
    assign last_of_run  = res.last;

endmodule

>>> src/sts_front.sv
`timescale 1ns / 1ps
module sts_front #(
    parameter int POSITION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [7:0]        text_byte,
    output logic              push,
    output sts_pkg::bundle_t  bundle,
    input  logic              full
);

    localparam logic [POSITION_BITS-1:0] PMAX = '1;
    localparam logic [POSITION_BITS-1:0] PONE = POSITION_BITS'(1);

    sts_pkg::mode_t mode_reg, mode_next;
    logic [63:0] kw_reg, kw_next;
    logic [3:0]  len_reg, len_next;
    logic [POSITION_BITS-1:0] line_reg, line_next, col_reg, col_next;
    logic [POSITION_BITS-1:0] start_reg, start_next, dot_reg, dot_next;
    logic qd_reg, qd_next, seen_reg, seen_next;

    sts_pkg::bundle_t b;
    logic [7:0] c, quote;
    logic go;
    logic [15:0] ln16, col16, start16, dot16;

    assign in_ready = !full;
    assign go = in_valid && in_ready;
    assign push = go;
    assign bundle = b;
    assign c = text_byte;
    assign quote = qd_reg ? 8'h22 : 8'h27;

    // positions are reported in their low 16 bits
    assign ln16    = 16'(line_reg);
    assign col16   = 16'(col_reg);
    assign start16 = 16'(start_reg);
    assign dot16   = 16'(dot_reg);

    function automatic logic is_alpha(input logic [7:0] x);
        return (x >= "A" && x <= "Z") || (x >= "a" && x <= "z");
    endfunction
    function automatic logic is_digit(input logic [7:0] x);
        return x >= "0" && x <= "9";
    endfunction

    always_comb
    begin
        logic [15:0] sc;
        logic        restart;
        mode_next  = mode_reg;
        kw_next    = kw_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        dot_next   = dot_reg;
        qd_next    = qd_reg;
        seen_next  = seen_reg;
        b          = '0;
        restart    = 1'b0;
        sc         = start16;

        // emit helper is inlined: slot index = b.count
        if (operation)
        begin
            case (mode_reg)
                sts_pkg::M_WORD:
                begin
                    b.res[0] = '{1'b1, sts_pkg::T_IDENT, 8'd0, ln16, sc, 1'b0};
                    b.kw_check = 1'b1; b.kw_text = kw_reg; b.kw_len = len_reg; b.count = 2'd1;
                end
                sts_pkg::M_NUM:
                begin
                    b.res[0] = '{1'b1, seen_reg ? sts_pkg::T_FLOATLIT : sts_pkg::T_INTLIT,
                                 8'd0, ln16, sc, 1'b0};
                    b.count = 2'd1;
                end
                sts_pkg::M_NUMDOT:
                begin
                    b.res[0] = '{1'b1, sts_pkg::T_INTLIT, 8'd0, ln16, sc, 1'b0};
                    b.res[1] = '{1'b1, sts_pkg::T_DOT, 8'd0, ln16, dot16, 1'b0};
                    b.count = 2'd2;
                end
                sts_pkg::M_STR, sts_pkg::M_STRQ:
                begin
                    b.res[0] = '{1'b1, sts_pkg::T_STRLIT, 8'd0, ln16, sc, 1'b0};
                    b.count = 2'd1;
                end
                sts_pkg::M_STRESC:
                begin
                    b.res[0] = '{1'b0, sts_pkg::T_STRLIT, 8'd0, ln16, sc, 1'b0};
                    b.res[1] = '{1'b1, sts_pkg::T_STRLIT, 8'd0, ln16, sc, 1'b0};
                    b.count = 2'd2;
                end
                sts_pkg::M_LT:
                begin
                    b.res[0] = '{1'b1, sts_pkg::T_LT, 8'd0, ln16, sc, 1'b0};
                    b.count = 2'd1;
                end
                sts_pkg::M_GT:
                begin
                    b.res[0] = '{1'b1, sts_pkg::T_GT, 8'd0, ln16, sc, 1'b0};
                    b.count = 2'd1;
                end
                sts_pkg::M_BANG:
                begin
                    b.res[0] = '{1'b1, sts_pkg::T_INVALID, 8'h21, ln16, sc, 1'b0};
                    b.count = 2'd1;
                end
                sts_pkg::M_MINUS:
                begin
                    b.res[0] = '{1'b1, sts_pkg::T_MINUS, 8'd0, ln16, sc, 1'b0};
                    b.count = 2'd1;
                end
                sts_pkg::M_SLASH:
                begin
                    b.res[0] = '{1'b1, sts_pkg::T_SLASH, 8'd0, ln16, sc, 1'b0};
                    b.count = 2'd1;
                end
                default: ;
            endcase
            b.res[b.count] = '{1'b1, sts_pkg::T_EOF, 8'd0, ln16, col16, 1'b0};
            b.count = b.count + 2'd1;
            mode_next  = sts_pkg::M_IDLE;
            line_next  = PONE;
            col_next   = PONE;
            start_next = PONE;
            dot_next   = PONE;
        end
        else
        begin
            case (mode_reg)
                sts_pkg::M_WORD:
                    if (is_alpha(c) || is_digit(c) || c == "_")
                    begin
                        if (len_reg < 4'd8)
                            kw_next[63 - 8*len_reg[2:0] -: 8] =
                                (c >= "a" && c <= "z") ? c - 8'd32 : c;
                        if (len_reg <= 4'd8) len_next = len_reg + 4'd1;
                        b.res[0] = '{1'b0, sts_pkg::T_IDENT, c, ln16, sc, 1'b0};
                        b.count = 2'd1;
                    end
                    else
                    begin
                        b.res[0] = '{1'b1, sts_pkg::T_IDENT, 8'd0, ln16, sc, 1'b0};
                        b.kw_check = 1'b1; b.kw_text = kw_reg; b.kw_len = len_reg;
                        b.count = 2'd1; restart = 1'b1;
                    end
                sts_pkg::M_NUM:
                    if (is_digit(c))
                    begin
                        b.res[0] = '{1'b0, seen_reg ? sts_pkg::T_FLOATLIT : sts_pkg::T_INTLIT,
                                     c, ln16, sc, 1'b0};
                        b.count = 2'd1;
                    end
                    else if (c == "." && !seen_reg)
                    begin
                        mode_next = sts_pkg::M_NUMDOT;
                        dot_next = col_reg;
                    end
                    else
                    begin
                        b.res[0] = '{1'b1, seen_reg ? sts_pkg::T_FLOATLIT : sts_pkg::T_INTLIT,
                                     8'd0, ln16, sc, 1'b0};
                        b.count = 2'd1; restart = 1'b1;
                    end
                sts_pkg::M_NUMDOT:
                    if (is_digit(c))
                    begin
                        seen_next = 1'b1;
                        b.res[0] = '{1'b0, sts_pkg::T_FLOATLIT, 8'h2E, ln16, sc, 1'b0};
                        b.res[1] = '{1'b0, sts_pkg::T_FLOATLIT, c, ln16, sc, 1'b0};
                        b.count = 2'd2;
                        mode_next = sts_pkg::M_NUM;
                    end
                    else
                    begin
                        b.res[0] = '{1'b1, sts_pkg::T_INTLIT, 8'd0, ln16, sc, 1'b0};
                        b.res[1] = '{1'b1, sts_pkg::T_DOT, 8'd0, ln16, dot16, 1'b0};
                        b.count = 2'd2; restart = 1'b1;
                    end
                sts_pkg::M_STR:
                    if (c == quote) mode_next = sts_pkg::M_STRQ;
                    else if (c == 8'h5C) mode_next = sts_pkg::M_STRESC;
                    else
                    begin
                        b.res[0] = '{1'b0, sts_pkg::T_STRLIT, c, ln16, sc, 1'b0};
                        b.count = 2'd1;
                    end
                sts_pkg::M_STRQ:
                    if (c == quote)
                    begin
                        b.res[0] = '{1'b0, sts_pkg::T_STRLIT, quote, ln16, sc, 1'b0};
                        b.count = 2'd1;
                        mode_next = sts_pkg::M_STR;
                    end
                    else
                    begin
                        b.res[0] = '{1'b1, sts_pkg::T_STRLIT, 8'd0, ln16, sc, 1'b0};
                        b.count = 2'd1; restart = 1'b1;
                    end
                sts_pkg::M_STRESC:
                begin
                    b.res[0] = '{1'b0, sts_pkg::T_STRLIT,
                                 c == "n" ? 8'd10 : c == "t" ? 8'd9 : c == "r" ? 8'd13 : c,
                                 ln16, sc, 1'b0};
                    b.count = 2'd1;
                    mode_next = sts_pkg::M_STR;
                end
                sts_pkg::M_LT:
                begin
                    b.count = 2'd1;
                    mode_next = sts_pkg::M_IDLE;
                    if (c == "=")
                        b.res[0] = '{1'b1, sts_pkg::T_LE, 8'd0, ln16, sc, 1'b0};
                    else if (c == ">")
                        b.res[0] = '{1'b1, sts_pkg::T_NE, 8'd0, ln16, sc, 1'b0};
                    else
                    begin
                        b.res[0] = '{1'b1, sts_pkg::T_LT, 8'd0, ln16, sc, 1'b0};
                        restart = 1'b1;
                    end
                end
                sts_pkg::M_GT:
                begin
                    b.count = 2'd1;
                    mode_next = sts_pkg::M_IDLE;
                    if (c == "=")
                        b.res[0] = '{1'b1, sts_pkg::T_GE, 8'd0, ln16, sc, 1'b0};
                    else
                    begin
                        b.res[0] = '{1'b1, sts_pkg::T_GT, 8'd0, ln16, sc, 1'b0};
                        restart = 1'b1;
                    end
                end
                sts_pkg::M_BANG:
                begin
                    b.count = 2'd1;
                    mode_next = sts_pkg::M_IDLE;
                    if (c == "=")
                        b.res[0] = '{1'b1, sts_pkg::T_NE, 8'd0, ln16, sc, 1'b0};
                    else
                    begin
                        b.res[0] = '{1'b1, sts_pkg::T_INVALID, 8'h21, ln16, sc, 1'b0};
                        restart = 1'b1;
                    end
                end
                sts_pkg::M_MINUS:
                    if (c == "-") mode_next = sts_pkg::M_LINECMT;
                    else
                    begin
                        b.res[0] = '{1'b1, sts_pkg::T_MINUS, 8'd0, ln16, sc, 1'b0};
                        b.count = 2'd1; restart = 1'b1;
                    end
                sts_pkg::M_SLASH:
                    if (c == "*") mode_next = sts_pkg::M_BLOCK;
                    else
                    begin
                        b.res[0] = '{1'b1, sts_pkg::T_SLASH, 8'd0, ln16, sc, 1'b0};
                        b.count = 2'd1; restart = 1'b1;
                    end
                sts_pkg::M_LINECMT:
                    if (c == 8'd10) mode_next = sts_pkg::M_IDLE;
                sts_pkg::M_BLOCK:
                    if (c == "*") mode_next = sts_pkg::M_BLOCKSTAR;
                sts_pkg::M_BLOCKSTAR:
                    if (c == "/") mode_next = sts_pkg::M_IDLE;
                    else if (c != "*") mode_next = sts_pkg::M_BLOCK;
                default: restart = 1'b1;
            endcase

            if (restart)
            begin
                mode_next  = sts_pkg::M_IDLE;
                start_next = col_reg;
                sc         = col16;
                if (is_alpha(c) || c == "_")
                begin
                    mode_next = sts_pkg::M_WORD;
                    kw_next[63:56] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
                    len_next = 4'd1;
                    b.res[b.count] = '{1'b0, sts_pkg::T_IDENT, c, ln16, sc, 1'b0};
                    b.count = b.count + 2'd1;
                end
                else if (is_digit(c))
                begin
                    mode_next = sts_pkg::M_NUM;
                    seen_next = 1'b0;
                    b.res[b.count] = '{1'b0, sts_pkg::T_INTLIT, c, ln16, sc, 1'b0};
                    b.count = b.count + 2'd1;
                end
                else if (c == 8'h27 || c == 8'h22)
                begin
                    mode_next = sts_pkg::M_STR;
                    qd_next = (c == 8'h22);
                end
                else if (c == " " || (c >= 8'd9 && c <= 8'd13))
                begin
                end
                else
                begin
                    b.res[b.count] = '{1'b1, sts_pkg::T_INVALID, 8'd0, ln16, sc, 1'b0};
                    case (c)
                        "(": b.res[b.count].ttype = sts_pkg::T_LPAREN;
                        ")": b.res[b.count].ttype = sts_pkg::T_RPAREN;
                        ",": b.res[b.count].ttype = sts_pkg::T_COMMA;
                        ";": b.res[b.count].ttype = sts_pkg::T_SEMI;
                        "*": b.res[b.count].ttype = sts_pkg::T_STAR;
                        ".": b.res[b.count].ttype = sts_pkg::T_DOT;
                        "+": b.res[b.count].ttype = sts_pkg::T_PLUS;
                        "=": b.res[b.count].ttype = sts_pkg::T_EQ;
                        "<": mode_next = sts_pkg::M_LT;
                        ">": mode_next = sts_pkg::M_GT;
                        "!": mode_next = sts_pkg::M_BANG;
                        "-": mode_next = sts_pkg::M_MINUS;
                        "/": mode_next = sts_pkg::M_SLASH;
                        default: b.res[b.count].value = c;
                    endcase
                    if (mode_next == sts_pkg::M_IDLE) b.count = b.count + 2'd1;
                end
            end

            if (c == 8'd10)
            begin
                if (line_reg != PMAX) line_next = line_reg + PONE;
                col_next = PONE;
            end
            else if (col_reg != PMAX)
                col_next = col_reg + PONE;
        end
        if (b.count != 2'd0) b.res[b.count - 2'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sts_pkg::M_IDLE;
            len_reg   <= '0;
            line_reg  <= PONE;
            col_reg   <= PONE;
            start_reg <= PONE;
            dot_reg   <= PONE;
            qd_reg    <= 1'b0;
            seen_reg  <= 1'b0;
            kw_reg    <= '0;
        end
        else if (go)
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            dot_reg   <= dot_next;
            qd_reg    <= qd_next;
            seen_reg  <= seen_next;
            kw_reg    <= (mode_reg != sts_pkg::M_WORD) && (mode_next == sts_pkg::M_WORD)
                         ? {kw_next[63:56], 56'd0} : kw_next;
        end
    end

endmodule

>>> src/sts_queue.sv
`timescale 1ns / 1ps
module sts_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sts_pkg::bundle_t push_data,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output sts_pkg::bundle_t head
);

    sts_pkg::bundle_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic wp_reg, rp_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
        end
    end

endmodule

>>> src/sts_back.sv
`timescale 1ns / 1ps
module sts_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  sts_pkg::bundle_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output sts_pkg::res_t    out_res
);

    logic [1:0]    idx_reg, idx_next;
    logic          valid_reg;
    sts_pkg::res_t res_reg;
    sts_pkg::res_t cur;
    logic          load, have;
    logic [6:0]    kw_type;

    always_comb
    begin
        kw_type = sts_pkg::T_IDENT;
        if (head.kw_len >= 4'd1 && head.kw_len <= 4'd8)
            for (int i = sts_pkg::KW_COUNT - 1; i >= 0; i--)
                if (head.kw_text == sts_pkg::kw_padded(i)) kw_type = 7'(i);
    end

    assign have = !empty && head.count != 2'd0;
    assign load = (!valid_reg || out_ready) && !empty;

    always_comb
    begin
        cur = head.res[idx_reg];
        if (idx_reg == 2'd0 && head.kw_check) cur.ttype = kw_type;
        idx_next = idx_reg;
        pop = 1'b0;
        if (load)
        begin
            if (!have || idx_reg + 2'd1 >= head.count)
            begin
                pop = 1'b1;
                idx_next = 2'd0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load) valid_reg <= have;
            else if (out_ready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) res_reg <= cur;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
